### src/dpd_pkg.sv
`default_nettype none

package dpd_pkg;

	localparam int PACKET_LEN = 5;
	localparam int POS_W = $clog2(PACKET_LEN);
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_LEN - 1);
	localparam logic [7:0] SPEED_CENTER = 8'd127;
	localparam logic [7:0] STOP_MASK_RESET = 8'h01;
	localparam logic [ADDR_W-1:0] ADDR_STOP_MASK = 3'd0;

	typedef enum logic [1:0] {
		ACT_HARD_STOP  = 2'd0,
		ACT_SET_MOTORS = 2'd1,
		ACT_NO_ACTION  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		DIR_STOP     = 2'd0,
		DIR_BACKWARD = 2'd1,
		DIR_FORWARD  = 2'd2
	} dir_t;

	typedef struct packed {
		dir_t       dir;
		logic [7:0] mag;
	} speed_t;

	// offset-binary speed byte to direction and magnitude
	function automatic speed_t split_speed(input logic [7:0] b);
		speed_t s;
		if (b == SPEED_CENTER) begin
			s.dir = DIR_STOP;
			s.mag = 8'd0;
		end else if (b < SPEED_CENTER) begin
			s.dir = DIR_BACKWARD;
			s.mag = SPEED_CENTER - b;
		end else begin
			s.dir = DIR_FORWARD;
			s.mag = b - SPEED_CENTER;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

### src/dpd_rx_if.sv
`default_nettype none

interface dpd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/dpd_cmd_if.sv
`default_nettype none

interface dpd_cmd_if;
	logic             valid;
	logic             ready;
	dpd_pkg::action_t action;
	dpd_pkg::dir_t    left_dir;
	logic [7:0]       left_speed;
	dpd_pkg::dir_t    right_dir;
	logic [7:0]       right_speed;

	modport source (output valid, output action, output left_dir, output left_speed,
		output right_dir, output right_speed, input ready);
	modport sink (input valid, input action, input left_dir, input left_speed,
		input right_dir, input right_speed, output ready);
endinterface

`default_nettype wire

### src/drive_packet_deframer.sv
// drive_packet_deframer
// Collects received bytes into fixed-length drive command packets and
// decodes each complete packet into one motor command word.
// rx channel (valid/ready): one received byte per word. Byte 0 of a packet
// is ignored, byte 1 is the flags byte, bytes 2 and 3 are the left and right
// offset-binary speeds, byte 4 is the xor checksum of bytes 1 to 3.
// cmd channel (valid/ready): one word per packet with action, directions and
// speed magnitudes.
// APB port: register 0 at address 0 is stop_mask (reset 0x01); a flags byte
// with any masked bit set gives a hard stop.
// Throughput: one byte per cycle while cmd is not stalled. The command word
// appears in the cycle after the last byte of the packet is accepted, from the
// output register. Decode is a single pass of compare and subtract logic.
// Reset clears the byte position and the output valid; stop_mask returns to
// its reset value. When cmd stalls with a word waiting, rx is held not ready
// until that word is taken, whatever the byte position.
`default_nettype none

module drive_packet_deframer (
	input  wire                               clk,
	input  wire                               arst_n,
	dpd_rx_if.sink                            rx,
	dpd_cmd_if.source                         cmd,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [dpd_pkg::ADDR_W-1:0]        paddr,
	input  wire  [dpd_pkg::DATA_W-1:0]        pwdata,
	output logic [dpd_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);

	logic [7:0]                stop_mask_q;
	logic [dpd_pkg::POS_W-1:0] pos_q;
	logic [7:0]                pkt_q [4];
	logic [7:0]                cur [4];
	logic                      accept;
	logic                      last;
	logic                      cmd_valid_q;
	dpd_pkg::action_t          action_q;
	dpd_pkg::speed_t           left_q;
	dpd_pkg::speed_t           right_q;
	dpd_pkg::action_t          action_d;
	dpd_pkg::speed_t           left_d;
	dpd_pkg::speed_t           right_d;

	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr == dpd_pkg::ADDR_STOP_MASK) begin
			prdata = {{(dpd_pkg::DATA_W-8){1'b0}}, stop_mask_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_mask_q <= dpd_pkg::STOP_MASK_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr == dpd_pkg::ADDR_STOP_MASK) begin
			stop_mask_q <= pwdata[7:0];
		end
	end

	assign rx.ready = !cmd_valid_q || cmd.ready;
	assign accept = rx.valid && rx.ready;
	assign last = (pos_q >= dpd_pkg::LAST_POS);

	// packet bytes 1 to 4 with the current byte merged in
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cur[i] = (pos_q == dpd_pkg::POS_W'(i + 1)) ? rx.rx_byte : pkt_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 4; i++) begin
				pkt_q[i] <= cur[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= last ? '0 : pos_q + 1'b1;
		end
	end

	always_comb begin
		action_d = dpd_pkg::ACT_NO_ACTION;
		left_d = '0;
		right_d = '0;
		if ((cur[0] & stop_mask_q) != 8'd0) begin
			action_d = dpd_pkg::ACT_HARD_STOP;
		end else if (cur[3] == (cur[0] ^ cur[1] ^ cur[2])) begin
			action_d = dpd_pkg::ACT_SET_MOTORS;
			left_d = dpd_pkg::split_speed(cur[1]);
			right_d = dpd_pkg::split_speed(cur[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (accept && last) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			action_q <= action_d;
			left_q <= left_d;
			right_q <= right_d;
		end
	end

	assign cmd.valid = cmd_valid_q;
	assign cmd.action = action_q;
	assign cmd.left_dir = left_q.dir;
	assign cmd.left_speed = left_q.mag;
	assign cmd.right_dir = right_q.dir;
	assign cmd.right_speed = right_q.mag;

endmodule

`default_nettype wire

### src/dpd_checker.sv
`default_nettype none

module dpd_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       rx_valid,
	input wire       rx_ready,
	input wire       cmd_valid,
	input wire       cmd_ready,
	input wire [1:0] action,
	input wire [1:0] left_dir,
	input wire [7:0] left_speed,
	input wire [1:0] right_dir,
	input wire [7:0] right_speed
);

	// a word held under stall stays
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(action))
		else $error("cmd word dropped under stall");

	// a new word only follows an accepted byte
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !$past(cmd_valid && !cmd_ready) |-> $past(rx_valid && rx_ready))
		else $error("cmd word without a byte");

	// only motor commands carry speeds
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && action != dpd_pkg::ACT_SET_MOTORS |->
		left_dir == dpd_pkg::DIR_STOP && right_dir == dpd_pkg::DIR_STOP &&
		left_speed == 8'd0 && right_speed == 8'd0)
		else $error("speed on a non-motor command");

	// stop direction goes with zero speed
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (left_dir == dpd_pkg::DIR_STOP) == (left_speed == 8'd0) &&
		(right_dir == dpd_pkg::DIR_STOP) == (right_speed == 8'd0))
		else $error("direction and speed disagree");

	// a stalled output blocks input
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |-> !rx_ready)
		else $error("byte taken while output full");

endmodule

bind drive_packet_deframer dpd_checker u_dpd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rx_valid   (rx.valid),
	.rx_ready   (rx.ready),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.action     (cmd.action),
	.left_dir   (cmd.left_dir),
	.left_speed (cmd.left_speed),
	.right_dir  (cmd.right_dir),
	.right_speed(cmd.right_speed)
);

`default_nettype wire

### tb/sv/tb_drive_packet_deframer.sv
`default_nettype none

module tb_drive_packet_deframer;

	typedef struct {
		dpd_pkg::action_t action;
		dpd_pkg::dir_t    left_dir;
		logic [7:0]       left_speed;
		dpd_pkg::dir_t    right_dir;
		logic [7:0]       right_speed;
	} drive_cmd_t;

	class drive_cmd_board_t;
		logic [7:0]  stop_mask;
		int unsigned position;
		logic [7:0]  held [4];
		drive_cmd_t  pending_cmds [$];
		int unsigned n_errors;
		int unsigned n_bytes;
		int unsigned n_stops;
		int unsigned n_moves;
		int unsigned n_ignored;

		function new();
			stop_mask = dpd_pkg::STOP_MASK_RESET;
			position = 0;
			foreach (held[i]) held[i] = 8'd0;
			n_errors = 0;
			n_bytes = 0;
			n_stops = 0;
			n_moves = 0;
			n_ignored = 0;
		endfunction

		function void decode_speed(input logic [7:0] b, output dpd_pkg::dir_t d,
			output logic [7:0] m);
			if (b > dpd_pkg::SPEED_CENTER) begin
				d = dpd_pkg::DIR_FORWARD;
				m = b - dpd_pkg::SPEED_CENTER;
			end else if (b < dpd_pkg::SPEED_CENTER) begin
				d = dpd_pkg::DIR_BACKWARD;
				m = dpd_pkg::SPEED_CENTER - b;
			end else begin
				d = dpd_pkg::DIR_STOP;
				m = 8'd0;
			end
		endfunction

		function void take_byte(input logic [7:0] b);
			drive_cmd_t c;
			n_bytes++;
			if (position >= 1 && position <= 4)
				held[position-1] = b;
			if (position + 1 < dpd_pkg::PACKET_LEN) begin
				position++;
			end else begin
				position = 0;
				c.action = dpd_pkg::ACT_NO_ACTION;
				c.left_dir = dpd_pkg::DIR_STOP;
				c.left_speed = 8'd0;
				c.right_dir = dpd_pkg::DIR_STOP;
				c.right_speed = 8'd0;
				if ((held[0] & stop_mask) != 8'd0) begin
					c.action = dpd_pkg::ACT_HARD_STOP;
				end else if (held[3] == (held[0] ^ held[1] ^ held[2])) begin
					c.action = dpd_pkg::ACT_SET_MOTORS;
					decode_speed(held[1], c.left_dir, c.left_speed);
					decode_speed(held[2], c.right_dir, c.right_speed);
				end
				pending_cmds.push_back(c);
			end
		endfunction

		function void compare_field(input string name, input int exp_v, input int act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				n_errors++;
			end
		endfunction

		function void check_word(input dpd_pkg::action_t a, input dpd_pkg::dir_t ld,
			input logic [7:0] ls, input dpd_pkg::dir_t rd, input logic [7:0] rs);
			drive_cmd_t e;
			if (pending_cmds.size() == 0) begin
				$error("command word with none expected: action %0d", a);
				n_errors++;
			end else begin
				e = pending_cmds.pop_front();
				case (e.action)
					dpd_pkg::ACT_HARD_STOP: n_stops++;
					dpd_pkg::ACT_SET_MOTORS: n_moves++;
					default: n_ignored++;
				endcase
				compare_field("action", e.action, a);
				compare_field("left_dir", e.left_dir, ld);
				compare_field("left_speed", e.left_speed, ls);
				compare_field("right_dir", e.right_dir, rd);
				compare_field("right_speed", e.right_speed, rs);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [dpd_pkg::ADDR_W-1:0] paddr;
	logic [dpd_pkg::DATA_W-1:0] pwdata;
	logic [dpd_pkg::DATA_W-1:0] prdata;
	logic pready;

	dpd_rx_if rx();
	dpd_cmd_if cmd();

	drive_cmd_board_t board = new();

	int src_idle_pct;
	int sink_stall_pct;
	bit stall_burst_req;

	drive_packet_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.cmd(cmd),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				board.check_word(cmd.action, cmd.left_dir, cmd.left_speed,
					cmd.right_dir, cmd.right_speed);
			if (rx.valid && rx.ready)
				board.take_byte(rx.rx_byte);
		end
	end

	// command sink with random stalls and one long hold-off
	initial begin
		bit burst_taken;
		int burst_left;
		burst_taken = 1'b0;
		burst_left = 0;
		cmd.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_burst_req && !burst_taken) begin
				burst_taken = 1'b1;
				burst_left = 300;
			end
			if (burst_left > 0) begin
				burst_left--;
				cmd.ready = 1'b0;
			end else begin
				cmd.ready = ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx.valid = 1'b0;
			rx.rx_byte = 8'($urandom);
			@(negedge clk);
		end
		rx.valid = 1'b1;
		rx.rx_byte = b;
		do @(posedge clk); while (!rx.ready);
		@(negedge clk);
	endtask

	task automatic send_packet(input logic [7:0] b0, input logic [7:0] flags,
		input logic [7:0] left, input logic [7:0] right, input bit good_sum);
		logic [7:0] sum;
		sum = flags ^ left ^ right;
		if (!good_sum)
			sum = sum ^ 8'($urandom_range(255, 1));
		send_byte(b0);
		send_byte(flags);
		send_byte(left);
		send_byte(right);
		send_byte(sum);
	endtask

	task automatic apb_read_mask();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = dpd_pkg::ADDR_STOP_MASK;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] != board.stop_mask) begin
			$error("stop_mask: expected %0d, got %0d", board.stop_mask, prdata[7:0]);
			board.n_errors++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_stop_mask(input logic [7:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = dpd_pkg::ADDR_STOP_MASK;
		pwdata = dpd_pkg::DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		board.stop_mask = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		apb_read_mask();
	endtask

	task automatic settle();
		rx.valid = 1'b0;
		while (board.pending_cmds.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_speed();
		case ($urandom_range(7))
			0: return 8'd127;
			1: return 8'd0;
			2: return 8'd255;
			3: return 8'd126;
			4: return 8'd128;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_flags(input logic [7:0] mask);
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'($urandom);
			default: return 8'($urandom) & ~mask;
		endcase
	endfunction

	task automatic run_phase(input logic [7:0] mask, input int idle_pct, input int stall_pct,
		input int packets, input bit with_burst);
		int k;
		settle();
		set_stop_mask(mask);
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (k = 0; k < packets; k++) begin
			if (with_burst && k == 20)
				stall_burst_req = 1'b1;
			// stray word shifts the framing
			if ($urandom_range(19) == 0)
				send_byte(8'($urandom));
			send_packet(8'($urandom), pick_flags(mask), pick_speed(), pick_speed(),
				$urandom_range(4) != 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = 8'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		stall_burst_req = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apb_read_mask();
		send_packet(8'd0, 8'd0, 8'd127, 8'd127, 1'b1);
		send_packet(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
		send_packet(8'h5a, 8'hff, 8'd200, 8'd10, 1'b1);
		send_packet(8'ha5, 8'hfe, 8'd126, 8'd128, 1'b1);
		send_packet(8'd0, 8'd0, 8'd100, 8'd50, 1'b0);

		run_phase(8'hff, 0, 0, 80, 1'b1);
		run_phase(8'h00, 75, 0, 80, 1'b0);
		run_phase(8'h80, 0, 75, 80, 1'b0);
		run_phase(8'($urandom), 13, 13, 80, 1'b0);
		run_phase(8'h01, 0, 0, 80, 1'b0);
		settle();

		$display("%0d rx words, %0d hard stop, %0d set motors, %0d no action commands",
			board.n_bytes, board.n_stops, board.n_moves, board.n_ignored);
		$display("stop masks 0x01, 0xff, 0x00, 0x80 and random; idle and stall mixes");
		if (board.n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
src/dpd_pkg.sv
src/dpd_rx_if.sv
src/dpd_cmd_if.sv
src/drive_packet_deframer.sv
src/dpd_checker.sv
tb/sv/tb_drive_packet_deframer.sv
